// ===== sv/bpgs_pkg.sv =====
// ----------------------------------------------------------------------------
// bpgs_pkg
// Shared types and constants of the breath phase gate and smoother.
// ----------------------------------------------------------------------------
package bpgs_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned TimeWidth    = 32;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_RANGE_LIMIT    = 3'd0,
    REG_MIN_AMPLITUDE  = 3'd1,
    REG_RATE_PER_MS    = 3'd2,
    REG_RATE_WINDOW_MS = 3'd3,
    REG_DUPLICATE_TOL  = 3'd4,
    REG_ALPHA          = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [14:0] range_limit;
    logic [14:0] min_amplitude;
    logic [15:0] rate_per_ms;
    logic [15:0] rate_window_ms;
    logic [14:0] duplicate_tol;
    logic [15:0] alpha;
  } cfg_t;

  localparam logic [14:0] RangeLimitRst    = 15'd16384;
  localparam logic [14:0] MinAmplitudeRst  = 15'd655;
  localparam logic [15:0] RatePerMsRst     = 16'd16777;
  localparam logic [15:0] RateWindowMsRst  = 16'd1000;
  localparam logic [14:0] DuplicateTolRst  = 15'd33;
  localparam logic [15:0] AlphaRst         = 16'd19661;

endpackage

// ===== sv/bpgs_if.sv =====
// ----------------------------------------------------------------------------
// bpgs_req_if / bpgs_rsp_if
// Valid/ready channels carrying phase samples in and smoothed results out.
// ----------------------------------------------------------------------------
interface bpgs_req_if #(
  parameter int unsigned PHASE_WIDTH = 16
);
  logic                                valid;
  logic                                ready;
  logic signed [PHASE_WIDTH-1:0]       phase;
  logic [bpgs_pkg::TimeWidth-1:0]      time_ms;

  modport source (output valid, output phase, output time_ms, input ready);
  modport sink   (input valid, input phase, input time_ms, output ready);
endinterface

interface bpgs_rsp_if #(
  parameter int unsigned PHASE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic signed [PHASE_WIDTH-1:0] smoothed_phase;
  logic                          has_value;

  modport source (output valid, output accepted, output smoothed_phase, output has_value,
                  input ready);
  modport sink   (input valid, input accepted, input smoothed_phase, input has_value,
                  output ready);
endinterface

// ===== sv/breath_phase_gate_and_smoother.sv =====
// ----------------------------------------------------------------------------
// breath_phase_gate_and_smoother
// Outlier-gated exponential smoother for a radar breath phase signal.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one phase sample (signed Q1.15) with a millisecond
//   timestamp; rsp_o returns one result per request: accepted flag, the held
//   smoothed phase after the request and the has-value flag. Configuration is
//   written through cfg_we_i / cfg_idx_i / cfg_data_i, one register per cycle;
//   the user must write only while no request is in flight; not enforced.
// Pipeline:
//   a request is captured in the input register, checked and averaged
//   there, and its result is held in the result register that drives
//   rsp_o. One request per cycle is sustained while rsp_o is ready; the
//   check, the rate multiply and the alpha multiply are combinational
//   between the two registers, so the held state is ready for the next request.
// Reset:
//   clears the held phase, timestamp and has-value flag and loads the
//   register defaults; both pipeline registers empty.
// Stall:
//   while rsp_o is held off, one more request is taken into the input
//   register, then req_i.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module breath_phase_gate_and_smoother #(
  parameter int unsigned PHASE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  bpgs_req_if.sink                            req_i,
  bpgs_rsp_if.source                          rsp_o,
  input  logic                                cfg_we_i,
  input  logic [bpgs_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [bpgs_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  bpgs_pkg::cfg_t                    cfg;

  logic                              in_valid_q;
  logic signed [PHASE_WIDTH-1:0]     in_phase_q;
  logic [bpgs_pkg::TimeWidth-1:0]    in_time_q;

  logic                              out_valid_q;
  logic                              out_acc_q;
  logic signed [PHASE_WIDTH-1:0]     out_phase_q;
  logic                              out_has_q;

  logic                              out_free;
  logic                              advance;
  logic                              acc;
  logic signed [PHASE_WIDTH-1:0]     smoothed;
  logic                              has_value;

  bpgs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign advance     = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || out_free;

  bpgs_gate #(
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_gate (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .upd_i            (advance),
    .phase_i          (in_phase_q),
    .time_ms_i        (in_time_q),
    .accepted_o       (acc),
    .smoothed_phase_o (smoothed),
    .has_value_o      (has_value)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_phase_q <= req_i.phase;
      in_time_q  <= req_i.time_ms;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_acc_q   <= acc;
      out_phase_q <= smoothed;
      out_has_q   <= has_value;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.accepted       = out_acc_q;
  assign rsp_o.smoothed_phase = out_phase_q;
  assign rsp_o.has_value      = out_has_q;

endmodule

// ===== sv/bpgs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bpgs_cfg_regs
// Write-only configuration registers with their reset values.
// ----------------------------------------------------------------------------
module bpgs_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bpgs_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [bpgs_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output bpgs_pkg::cfg_t                      cfg_o
);

  bpgs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpgs_pkg::REG_RANGE_LIMIT:    cfg_d.range_limit    = cfg_data_i[14:0];
        bpgs_pkg::REG_MIN_AMPLITUDE:  cfg_d.min_amplitude  = cfg_data_i[14:0];
        bpgs_pkg::REG_RATE_PER_MS:    cfg_d.rate_per_ms    = cfg_data_i;
        bpgs_pkg::REG_RATE_WINDOW_MS: cfg_d.rate_window_ms = cfg_data_i;
        bpgs_pkg::REG_DUPLICATE_TOL:  cfg_d.duplicate_tol  = cfg_data_i[14:0];
        bpgs_pkg::REG_ALPHA:          cfg_d.alpha          = cfg_data_i;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_limit    <= bpgs_pkg::RangeLimitRst;
      cfg_q.min_amplitude  <= bpgs_pkg::MinAmplitudeRst;
      cfg_q.rate_per_ms    <= bpgs_pkg::RatePerMsRst;
      cfg_q.rate_window_ms <= bpgs_pkg::RateWindowMsRst;
      cfg_q.duplicate_tol  <= bpgs_pkg::DuplicateTolRst;
      cfg_q.alpha          <= bpgs_pkg::AlphaRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/bpgs_gate.sv =====
// ----------------------------------------------------------------------------
// bpgs_gate
// Outlier checks on one sample and the exponential average update of the
// held phase, timestamp and has-value flag.
// ----------------------------------------------------------------------------
module bpgs_gate #(
  parameter int unsigned PHASE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bpgs_pkg::cfg_t                      cfg_i,
  input  logic                                upd_i,
  input  logic signed [PHASE_WIDTH-1:0]       phase_i,
  input  logic [bpgs_pkg::TimeWidth-1:0]      time_ms_i,
  output logic                                accepted_o,
  output logic signed [PHASE_WIDTH-1:0]       smoothed_phase_o,
  output logic                                has_value_o
);

  localparam int unsigned P  = PHASE_WIDTH;
  localparam int unsigned MW = (P > 15) ? P : 15;
  localparam int unsigned DW = (P + 1 > 15) ? P + 1 : 15;
  localparam int unsigned CW = (P + 9 > 32) ? P + 9 : 32;

  logic signed [P-1:0]               held_q, held_d;
  logic                              valid_q, valid_d;
  logic [bpgs_pkg::TimeWidth-1:0]    last_q, last_d;

  logic [P-1:0]                      mag;
  logic signed [P:0]                 diff;
  logic [P:0]                        dmag;
  logic [bpgs_pkg::TimeWidth-1:0]    dt;
  logic                              in_window;
  logic [31:0]                       bound;
  logic [P+8:0]                      dmag_scaled;
  logic                              too_far, too_near, too_fast, is_dup, ok;
  logic signed [P+17:0]              prod;

  // magnitude as unsigned: the most negative code gives 2^(P-1)
  assign mag  = phase_i[P-1] ? (~phase_i + 1'b1) : phase_i;
  assign diff = {phase_i[P-1], phase_i} - {held_q[P-1], held_q};
  assign dmag = diff[P] ? (~diff + 1'b1) : diff;
  assign dt   = time_ms_i - last_q;

  assign too_far  = MW'(mag) > MW'(cfg_i.range_limit);
  assign too_near = MW'(mag) < MW'(cfg_i.min_amplitude);

  // dt below the 16 bit window, so its low half carries the whole value
  assign in_window   = valid_q && (dt != '0)
                       && (dt < bpgs_pkg::TimeWidth'(cfg_i.rate_window_ms));
  assign bound       = cfg_i.rate_per_ms * dt[15:0];
  assign dmag_scaled = {dmag, 8'b0};
  assign too_fast    = in_window && (CW'(dmag_scaled) > CW'(bound));

  assign is_dup = valid_q && (DW'(dmag) < DW'(cfg_i.duplicate_tol));
  assign ok     = !too_far && !too_near && !too_fast && !is_dup;

  // alpha is Q0.16; taking bits above 16 floors toward minus infinity
  assign prod = $signed({1'b0, cfg_i.alpha}) * diff;

  always_comb begin
    held_d  = held_q;
    valid_d = valid_q;
    last_d  = last_q;
    if (ok) begin
      held_d  = held_q + prod[P+15:16];
      valid_d = 1'b1;
      last_d  = time_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      valid_q <= 1'b0;
      last_q  <= '0;
    end else if (upd_i) begin
      held_q  <= held_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  assign accepted_o       = ok;
  assign smoothed_phase_o = held_d;
  assign has_value_o      = valid_d;

endmodule
